@@ src/baro_temp_pressure_compensation_core_assert.svh @@
// Assertion macros for the barometric compensation core.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_CORE_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BTPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/btpc_pkg.sv @@
// Shared types, constants and divider step function for the compensation core.
`default_nettype none

package btpc_pkg;

	localparam int DATA_W         = 64;
	localparam int DEN_W          = 31;
	localparam int DIV_STEP_BITS  = 4;
	localparam int DIV_STAGES     = DATA_W / DIV_STEP_BITS;
	localparam int CFG_INDEX_W    = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_TEMP  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_PLOW  = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_PHIGH = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_NINE  = CFG_INDEX_W'(3);

	localparam logic [24:0] PRESS_MAX = 25'h1FF_FFFF;

	typedef struct packed {
		logic signed [15:0] tc;
		logic               zero;
	} btpc_side_t;

	typedef struct packed {
		logic [DATA_W-1:0] nq;
		logic [DEN_W-1:0]  rem;
		logic [DEN_W-1:0]  den;
		logic              neg;
		btpc_side_t        side;
	} btpc_div_t;

	// restoring division, DIV_STEP_BITS quotient bits per call
	function automatic btpc_div_t div_steps(input btpc_div_t s);
		btpc_div_t   r;
		logic [DEN_W:0] t;
		r = s;
		for (int k = 0; k < DIV_STEP_BITS; k++) begin
			t = {r.rem, r.nq[DATA_W-1]};
			if (t >= {1'b0, r.den}) begin
				r.rem = DEN_W'(t - {1'b0, r.den});
				r.nq  = {r.nq[DATA_W-2:0], 1'b1};
			end else begin
				r.rem = t[DEN_W-1:0];
				r.nq  = {r.nq[DATA_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/btpc_divider.sv @@
// Pipelined signed-magnitude divider for the pressure quotient.
`default_nettype none
`include "baro_temp_pressure_compensation_core_assert.svh"

module btpc_divider (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire btpc_pkg::btpc_div_t  req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output btpc_pkg::btpc_div_t       rsp
);
	import btpc_pkg::*;

	localparam int LAST = DIV_STAGES - 1;

	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES-1:0] en;
	btpc_div_t             stg_s [DIV_STAGES];

	always_comb begin
		en[LAST] = !vld_s[LAST] || !rsp_stall;
		for (int i = LAST - 1; i >= 0; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	assign req_stall = !en[0];
	assign rsp_valid = vld_s[LAST];
	assign rsp       = stg_s[LAST];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (en[g]) begin
					vld_s[g] <= req_valid;
				end
			end
			always_ff @(posedge clk) begin
				if (en[g]) begin
					stg_s[g] <= div_steps(req);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (en[g]) begin
					vld_s[g] <= vld_s[g-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en[g]) begin
					stg_s[g] <= div_steps(stg_s[g-1]);
				end
			end
		end
	end

	`BTPC_ASSERT_NOW(a_div_full_blocks, (&vld_s) && rsp_stall, req_stall, "divider took a request while full and stalled")
	`BTPC_ASSERT_NOW(a_div_rem_bound, vld_s[LAST] && (stg_s[LAST].den != '0), stg_s[LAST].rem < stg_s[LAST].den, "divider remainder not below divisor")
	`BTPC_ASSERT_NEXT(a_div_hold, vld_s[LAST] && rsp_stall, vld_s[LAST] && $stable(stg_s[LAST]), "divider lost a stalled quotient")

endmodule

`default_nettype wire

@@ src/baro_temp_pressure_compensation_core.sv @@
// Top level of the barometric temperature and pressure compensation core.
// Usage:
//   Sample channel: temperature_raw and pressure_raw with sample_valid; a request
//   is taken at a clock edge with sample_valid high and sample_stall low.
//   Result channel: temperature_centi, pressure_q8, pressure_valid with
//   result_valid; the receiver holds result_stall high to keep a result.
//   Config channel: cfg_index / cfg_data with cfg_valid, cfg_ready always high.
//   Index 0..3 load the calibration words; other indexes are dropped. Write
//   calibration only while no request is in flight.
//   Pipeline: 33 register stages from the accepting edge to result_valid (11
//   front stages, 16 divider stages at 4 quotient bits each, 6 back).
//   Throughput: one request per cycle while result_stall is low; the 64-bit
//   quotient unit is fully pipelined.
//   Stall: each stage advances when it is empty or the next one advances, so
//   bubbles are squeezed out and sample_stall only rises when every stage ahead
//   is occupied.
//   Reset (arst_n low): calibration words clear to zero, pipeline empties.
`default_nettype none
`include "baro_temp_pressure_compensation_core_assert.svh"

module baro_temp_pressure_compensation_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 sample_valid,
	output logic                                      sample_stall,
	input  wire logic [19:0]                          temperature_raw,
	input  wire logic [19:0]                          pressure_raw,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic signed [15:0]                        temperature_centi,
	output logic [24:0]                               pressure_q8,
	output logic                                      pressure_valid,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [btpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [63:0]                          cfg_data
);
	import btpc_pkg::*;

	// calibration
	logic [15:0]        t1_q, p1_q;
	logic signed [15:0] t2_q, t3_q, p2_q, p3_q, p4_q;
	logic signed [15:0] p5_q, p6_q, p7_q, p8_q, p9_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q <= '0; t2_q <= '0; t3_q <= '0;
			p1_q <= '0; p2_q <= '0; p3_q <= '0; p4_q <= '0;
			p5_q <= '0; p6_q <= '0; p7_q <= '0; p8_q <= '0;
			p9_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CALIB_TEMP: begin
					t1_q <= cfg_data[15:0];
					t2_q <= cfg_data[31:16];
					t3_q <= cfg_data[47:32];
				end
				CFG_CALIB_PLOW: begin
					p1_q <= cfg_data[15:0];
					p2_q <= cfg_data[31:16];
					p3_q <= cfg_data[47:32];
					p4_q <= cfg_data[63:48];
				end
				CFG_CALIB_PHIGH: begin
					p5_q <= cfg_data[15:0];
					p6_q <= cfg_data[31:16];
					p7_q <= cfg_data[47:32];
					p8_q <= cfg_data[63:48];
				end
				CFG_CALIB_NINE: begin
					p9_q <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15;
	logic vld_s16, vld_s17;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;
	logic en_s9, en_s10, en_s11, en_s12, en_s13, en_s14, en_s15;
	logic en_s16, en_s17;

	logic      div_req_stall, div_rsp_valid;
	btpc_div_t div_req, div_rsp;

	assign en_s17 = !vld_s17 || !result_stall;
	assign en_s16 = !vld_s16 || en_s17;
	assign en_s15 = !vld_s15 || en_s16;
	assign en_s14 = !vld_s14 || en_s15;
	assign en_s13 = !vld_s13 || en_s14;
	assign en_s12 = !vld_s12 || en_s13;
	assign en_s11 = !vld_s11 || !div_req_stall;
	assign en_s10 = !vld_s10 || en_s11;
	assign en_s9  = !vld_s9  || en_s10;
	assign en_s8  = !vld_s8  || en_s9;
	assign en_s7  = !vld_s7  || en_s8;
	assign en_s6  = !vld_s6  || en_s7;
	assign en_s5  = !vld_s5  || en_s6;
	assign en_s4  = !vld_s4  || en_s5;
	assign en_s3  = !vld_s3  || en_s4;
	assign en_s2  = !vld_s2  || en_s3;
	assign en_s1  = !vld_s1  || en_s2;

	assign sample_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; vld_s10 <= 1'b0; vld_s11 <= 1'b0; vld_s12 <= 1'b0;
			vld_s13 <= 1'b0; vld_s14 <= 1'b0; vld_s15 <= 1'b0; vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
		end else begin
			if (en_s1)  vld_s1  <= sample_valid;
			if (en_s2)  vld_s2  <= vld_s1;
			if (en_s3)  vld_s3  <= vld_s2;
			if (en_s4)  vld_s4  <= vld_s3;
			if (en_s5)  vld_s5  <= vld_s4;
			if (en_s6)  vld_s6  <= vld_s5;
			if (en_s7)  vld_s7  <= vld_s6;
			if (en_s8)  vld_s8  <= vld_s7;
			if (en_s9)  vld_s9  <= vld_s8;
			if (en_s10) vld_s10 <= vld_s9;
			if (en_s11) vld_s11 <= vld_s10;
			if (en_s12) vld_s12 <= div_rsp_valid;
			if (en_s13) vld_s13 <= vld_s12;
			if (en_s14) vld_s14 <= vld_s13;
			if (en_s15) vld_s15 <= vld_s14;
			if (en_s16) vld_s16 <= vld_s15;
			if (en_s17) vld_s17 <= vld_s16;
		end
	end

	// s1: raw readings
	logic [19:0] at_s1, ap_s1;
	always_ff @(posedge clk) begin
		if (en_s1) begin
			at_s1 <= temperature_raw;
			ap_s1 <= pressure_raw;
		end
	end

	// s2: temperature products
	logic signed [17:0] d1_c;
	logic signed [16:0] d2_c;
	logic signed [33:0] v1p_c, sq_c;
	logic signed [33:0] v1p_s2;
	logic [32:0]        sq_s2;
	logic [19:0]        ap_s2;

	assign d1_c  = $signed({1'b0, at_s1[19:3]}) - $signed({1'b0, t1_q, 1'b0});
	assign d2_c  = $signed({1'b0, at_s1[19:4]}) - $signed({1'b0, t1_q});
	assign v1p_c = 34'(d1_c) * 34'(t2_q);
	assign sq_c  = 34'(d2_c) * 34'(d2_c);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			v1p_s2 <= v1p_c;
			sq_s2  <= sq_c[32:0];
			ap_s2  <= ap_s1;
		end
	end

	// s3
	logic signed [37:0] v2p_c, v2p_s3;
	logic signed [22:0] v1_s3;
	logic [19:0]        ap_s3;

	assign v2p_c = 38'($signed({1'b0, sq_s2[32:12]})) * 38'(t3_q);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			v1_s3  <= v1p_s2[33:11];
			v2p_s3 <= v2p_c;
			ap_s3  <= ap_s2;
		end
	end

	// s4: fine temperature
	logic signed [24:0] tf_c, tf_s4;
	logic [19:0]        ap_s4;

	assign tf_c = 25'(v1_s3) + 25'($signed(v2p_s3[37:14]));

	always_ff @(posedge clk) begin
		if (en_s4) begin
			tf_s4 <= tf_c;
			ap_s4 <= ap_s3;
		end
	end

	// s5: pressure offset products, temperature in centidegrees
	logic signed [25:0] a_c;
	logic signed [51:0] aa_c, aa_s5;
	logic signed [41:0] ap5_c, ap2_c, ap5_s5, ap2_s5;
	logic signed [27:0] tf5_c;
	logic signed [19:0] tcw_c;
	logic signed [15:0] tc_c, tc_s5;
	logic [19:0]        ap_s5;

	assign a_c   = 26'(tf_s4) - 26'sd128000;
	assign aa_c  = 52'(a_c) * 52'(a_c);
	assign ap5_c = 42'(a_c) * 42'(p5_q);
	assign ap2_c = 42'(a_c) * 42'(p2_q);
	assign tf5_c = (28'(tf_s4) <<< 2) + 28'(tf_s4) + 28'sd128;
	assign tcw_c = $signed(tf5_c[27:8]);

	always_comb begin
		if (tcw_c > 20'sd32767) begin
			tc_c = 16'sh7FFF;
		end else if (tcw_c < -20'sd32768) begin
			tc_c = 16'sh8000;
		end else begin
			tc_c = tcw_c[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			aa_s5  <= aa_c;
			ap5_s5 <= ap5_c;
			ap2_s5 <= ap2_c;
			tc_s5  <= tc_c;
			ap_s5  <= ap_s4;
		end
	end

	// s6
	logic signed [67:0] aa6_c, aa3_c;
	logic signed [63:0] aa6_s6, aa3_s6;
	logic signed [41:0] ap5_s6, ap2_s6;
	logic signed [15:0] tc_s6;
	logic [19:0]        ap_s6;

	assign aa6_c = 68'(aa_s5) * 68'(p6_q);
	assign aa3_c = 68'(aa_s5) * 68'(p3_q);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			aa6_s6 <= aa6_c[63:0];
			aa3_s6 <= aa3_c[63:0];
			ap5_s6 <= ap5_s5;
			ap2_s6 <= ap2_s5;
			tc_s6  <= tc_s5;
			ap_s6  <= ap_s5;
		end
	end

	// s7
	logic signed [63:0] b_c, a2_c, b_s7, a2_s7;
	logic signed [15:0] tc_s7;
	logic [19:0]        ap_s7;

	assign b_c  = aa6_s6 + (64'(ap5_s6) <<< 17) + (64'(p4_q) <<< 35);
	assign a2_c = (aa3_s6 >>> 8) + (64'(ap2_s6) <<< 12);

	always_ff @(posedge clk) begin
		if (en_s7) begin
			b_s7  <= b_c;
			a2_s7 <= a2_c;
			tc_s7 <= tc_s6;
			ap_s7 <= ap_s6;
		end
	end

	// s8: divisor and numerator base
	logic [63:0]        base_c, x_c, x_s8;
	logic [79:0]        a3p_c;
	logic [20:0]        pd_c;
	logic [DEN_W-1:0]   den_s8;
	logic signed [15:0] tc_s8;

	assign base_c = 64'h0000_8000_0000_0000 + $unsigned(a2_s7);
	assign a3p_c  = 80'(base_c) * 80'(p1_q);
	assign pd_c   = 21'h10_0000 - {1'b0, ap_s7};
	assign x_c    = ({43'd0, pd_c} << 31) - $unsigned(b_s7);

	always_ff @(posedge clk) begin
		if (en_s8) begin
			den_s8 <= a3p_c[63:33];
			x_s8   <= x_c;
			tc_s8  <= tc_s7;
		end
	end

	// s9, s10: numerator times 25, then times 125
	logic [63:0]        x25_s9, num_s10;
	logic [DEN_W-1:0]   den_s9, den_s10;
	logic signed [15:0] tc_s9, tc_s10;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			x25_s9 <= (x_s8 << 4) + (x_s8 << 3) + x_s8;
			den_s9 <= den_s8;
			tc_s9  <= tc_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s10) begin
			num_s10 <= (x25_s9 << 7) - (x25_s9 << 2) + x25_s9;
			den_s10 <= den_s9;
			tc_s10  <= tc_s9;
		end
	end

	// s11: magnitudes for the divider
	logic [63:0]        mag_s11;
	logic [DEN_W-1:0]   dmag_s11;
	logic               neg_s11, zero_s11;
	logic signed [15:0] tc_s11;

	always_ff @(posedge clk) begin
		if (en_s11) begin
			mag_s11  <= num_s10[63] ? (64'd0 - num_s10) : num_s10;
			dmag_s11 <= den_s10[DEN_W-1] ? (DEN_W'(0) - den_s10) : den_s10;
			neg_s11  <= num_s10[63] ^ den_s10[DEN_W-1];
			zero_s11 <= (den_s10 == '0);
			tc_s11   <= tc_s10;
		end
	end

	always_comb begin
		div_req.nq        = mag_s11;
		div_req.rem       = '0;
		div_req.den       = dmag_s11;
		div_req.neg       = neg_s11;
		div_req.side.tc   = tc_s11;
		div_req.side.zero = zero_s11;
	end

	btpc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (vld_s11),
		.req_stall (div_req_stall),
		.req       (div_req),
		.rsp_valid (div_rsp_valid),
		.rsp_stall (!en_s12),
		.rsp       (div_rsp)
	);

	// s12: signed quotient
	logic signed [63:0] p_s12;
	btpc_side_t         side_s12;

	always_ff @(posedge clk) begin
		if (en_s12) begin
			p_s12    <= div_rsp.neg ? $signed(64'd0 - div_rsp.nq) : $signed(div_rsp.nq);
			side_s12 <= div_rsp.side;
		end
	end

	// s13: P9 and P8 products
	logic signed [50:0] ps51_c;
	logic signed [66:0] m1_c;
	logic signed [79:0] m8_c;
	logic [63:0]        m1_s13;
	logic signed [63:0] m8_s13, p_s13;
	btpc_side_t         side_s13;

	assign ps51_c = $signed(p_s12[63:13]);
	assign m1_c   = 67'(p9_q) * 67'(ps51_c);
	assign m8_c   = 80'(p8_q) * 80'(p_s12);

	always_ff @(posedge clk) begin
		if (en_s13) begin
			m1_s13   <= m1_c[63:0];
			m8_s13   <= m8_c[63:0];
			p_s13    <= p_s12;
			side_s13 <= side_s12;
		end
	end

	// s14: low half of the 64x64 product in 32-bit partial products
	logic [63:0]        psx_c, ll_c, lh_c, hl_c, ll_s14;
	logic [31:0]        cross_s14;
	logic signed [63:0] m8_s14, p_s14;
	btpc_side_t         side_s14;

	assign psx_c = {{13{p_s13[63]}}, p_s13[63:13]};
	assign ll_c  = 64'(m1_s13[31:0]) * 64'(psx_c[31:0]);
	assign lh_c  = 64'(m1_s13[31:0]) * 64'(psx_c[63:32]);
	assign hl_c  = 64'(m1_s13[63:32]) * 64'(psx_c[31:0]);

	always_ff @(posedge clk) begin
		if (en_s14) begin
			ll_s14    <= ll_c;
			cross_s14 <= lh_c[31:0] + hl_c[31:0];
			m8_s14    <= m8_s13;
			p_s14     <= p_s13;
			side_s14  <= side_s13;
		end
	end

	// s15
	logic signed [63:0] prod_c, av_s15, bv_s15, p_s15;
	btpc_side_t         side_s15;

	assign prod_c = $signed(ll_s14 + {cross_s14, 32'd0});

	always_ff @(posedge clk) begin
		if (en_s15) begin
			av_s15   <= prod_c >>> 25;
			bv_s15   <= m8_s14 >>> 19;
			p_s15    <= p_s14;
			side_s15 <= side_s14;
		end
	end

	// s16
	logic signed [63:0] sum_s16;
	btpc_side_t         side_s16;

	always_ff @(posedge clk) begin
		if (en_s16) begin
			sum_s16  <= p_s15 + av_s15 + bv_s15;
			side_s16 <= side_s15;
		end
	end

	// s17: offset, saturation, output register
	logic signed [63:0] r_c;
	logic [24:0]        pq_c, pq_s17;
	logic signed [15:0] tc_s17;
	logic               pv_s17;

	assign r_c = (sum_s16 >>> 8) + (64'(p7_q) <<< 4);

	always_comb begin
		if (side_s16.zero || r_c[63]) begin
			pq_c = '0;
		end else if (r_c > 64'sh1FF_FFFF) begin
			pq_c = PRESS_MAX;
		end else begin
			pq_c = r_c[24:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s17) begin
			pq_s17 <= pq_c;
			tc_s17 <= side_s16.tc;
			pv_s17 <= !side_s16.zero;
		end
	end

	assign result_valid      = vld_s17;
	assign temperature_centi = tc_s17;
	assign pressure_q8       = pq_s17;
	assign pressure_valid    = pv_s17;

	`BTPC_ASSERT_NOW(a_zero_div_clears, result_valid && !pressure_valid, pressure_q8 == '0, "pressure not cleared on zero divisor")
	`BTPC_ASSERT_NEXT(a_out_load, en_s17 && vld_s16, result_valid, "result lost entering output register")
	`BTPC_ASSERT_NEXT(a_cfg_nine, cfg_valid && cfg_ready && (cfg_index == CFG_CALIB_NINE), $unsigned(p9_q) == $past(cfg_data[15:0]), "P9 write not taken")

endmodule

`default_nettype wire

@@ sim/baro_temp_pressure_compensation_core_test.sv @@
// Self-checking testbench for the barometric temperature and pressure compensation core.
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_core_test;
	import btpc_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = CFG_INDEX_W'(9);
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic signed [15:0] centi;
		logic [24:0]        press;
		logic               press_ok;
	} reading_t;

	class compensation_scoreboard;
		logic [47:0] calib_t;
		logic [63:0] calib_pl;
		logic [63:0] calib_ph;
		logic [15:0] calib_p9;
		reading_t    pending[$];
		int          errors;
		int          checked;
		int          invalid_seen;

		function new();
			calib_t = '0;
			calib_pl = '0;
			calib_ph = '0;
			calib_p9 = '0;
			errors = 0;
			checked = 0;
			invalid_seen = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
			case (idx)
				CFG_CALIB_TEMP:  calib_t = data[47:0];
				CFG_CALIB_PLOW:  calib_pl = data;
				CFG_CALIB_PHIGH: calib_ph = data;
				CFG_CALIB_NINE:  calib_p9 = data[15:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [19:0] t_raw, logic [19:0] p_raw);
			logic signed [63:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
			logic signed [63:0] d1, d2, v1, v2, tf, tc, a, b, x, num, y, z;
			logic [63:0] ua, ub, q;
			reading_t r;
			at = {44'b0, t_raw};
			ap = {44'b0, p_raw};
			t1 = {48'b0, calib_t[15:0]};
			t2 = {{48{calib_t[31]}}, calib_t[31:16]};
			t3 = {{48{calib_t[47]}}, calib_t[47:32]};
			p1 = {48'b0, calib_pl[15:0]};
			p2 = {{48{calib_pl[31]}}, calib_pl[31:16]};
			p3 = {{48{calib_pl[47]}}, calib_pl[47:32]};
			p4 = {{48{calib_pl[63]}}, calib_pl[63:48]};
			p5 = {{48{calib_ph[15]}}, calib_ph[15:0]};
			p6 = {{48{calib_ph[31]}}, calib_ph[31:16]};
			p7 = {{48{calib_ph[47]}}, calib_ph[47:32]};
			p8 = {{48{calib_ph[63]}}, calib_ph[63:48]};
			p9 = {{48{calib_p9[15]}}, calib_p9};

			d1 = (at >>> 3) - (t1 <<< 1);
			v1 = (d1 * t2) >>> 11;
			d2 = (at >>> 4) - t1;
			v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
			tf = v1 + v2;
			tc = (tf * 64'sd5 + 64'sd128) >>> 8;
			if (tc < -64'sd32768)
				tc = -64'sd32768;
			else if (tc > 64'sd32767)
				tc = 64'sd32767;
			r.centi = tc[15:0];

			a = tf - 64'sd128000;
			b = a * a * p6;
			b = b + ((a * p5) <<< 17);
			b = b + (p4 <<< 35);
			a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
			a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
			if (a == 0) begin
				r.press = '0;
				r.press_ok = 1'b0;
			end else begin
				x = 64'sd1048576 - ap;
				num = ((x <<< 31) - b) * 64'sd3125;
				ua = num[63] ? -num : num;
				ub = a[63] ? -a : a;
				q = ua / ub;
				x = (num[63] != a[63]) ? -q : q;
				y = (p9 * (x >>> 13) * (x >>> 13)) >>> 25;
				z = (p8 * x) >>> 19;
				x = ((x + y + z) >>> 8) + (p7 <<< 4);
				if (x < 0)
					r.press = '0;
				else if (x > 64'sd33554431)
					r.press = PRESS_MAX;
				else
					r.press = x[24:0];
				r.press_ok = 1'b1;
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [15:0] centi, logic [24:0] press, logic ok);
			reading_t e;
			if (pending.size() == 0) begin
				$error("unexpected result: temperature_centi=%0d pressure_q8=%0d", centi, press);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (!e.press_ok)
				invalid_seen++;
			if (centi !== e.centi) begin
				$error("temperature_centi: expected %0d, actual %0d", e.centi, centi);
				errors++;
			end
			if (press !== e.press) begin
				$error("pressure_q8: expected %0d, actual %0d", e.press, press);
				errors++;
			end
			if (ok !== e.press_ok) begin
				$error("pressure_valid: expected %0d, actual %0d", e.press_ok, ok);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	logic [19:0] temperature_raw;
	logic [19:0] pressure_raw;
	logic result_valid;
	logic result_stall;
	logic signed [15:0] temperature_centi;
	logic [24:0] pressure_q8;
	logic pressure_valid;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	compensation_scoreboard sb;
	bit quiet;
	int stall_left;
	int idle_cycles;
	int sent;

	baro_temp_pressure_compensation_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.temperature_raw(temperature_raw),
		.pressure_raw(pressure_raw),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.temperature_centi(temperature_centi),
		.pressure_q8(pressure_q8),
		.pressure_valid(pressure_valid),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: random stall per request
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				sb.check_result(temperature_centi, pressure_q8, pressure_valid);
				stall_left = quiet ? 0 : $urandom_range(0, 19);
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("** baro_temp_pressure_compensation_core: FAILED **");
			$finish;
		end
	end

	task automatic send_sample(logic [19:0] t_raw, logic [19:0] p_raw);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		temperature_raw <= t_raw;
		pressure_raw <= p_raw;
		do @(posedge clk); while (sample_stall);
		sb.note_sample(t_raw, p_raw);
		sent++;
	endtask

	task automatic write_calib(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic load_calib(logic [47:0] ct, logic [63:0] pl, logic [63:0] ph,
			logic [15:0] p9);
		drain();
		write_calib(CFG_CALIB_TEMP, {16'hFFFF, ct});
		write_calib(CFG_CALIB_PLOW, pl);
		write_calib(CFG_CALIB_PHIGH, ph);
		write_calib(CFG_CALIB_NINE, {48'hFFFF_FFFF_FFFF, p9});
		write_calib(CFG_UNUSED, 64'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	task automatic random_samples(int n);
		logic [19:0] t_raw, p_raw;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				t_raw = 20'($urandom_range(400000, 600000));
				p_raw = 20'($urandom_range(200000, 500000));
			end else begin
				t_raw = 20'($urandom());
				p_raw = 20'($urandom());
			end
			send_sample(t_raw, p_raw);
			if (i == n / 2)
				drain();
		end
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		sent = 0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		temperature_raw = '0;
		pressure_raw = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all calibration zero: divisor is zero
		send_sample(20'h00000, 20'h00000);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'd519888, 20'd415148);

		// typical factory calibration
		load_calib({16'hFC18, 16'd26435, 16'd27504},
			{16'd2855, 16'd3024, -16'sd10685, 16'd36477},
			{16'd15500 - 16'd30100, 16'd15500, -16'sd7, 16'd140}, 16'd6000);
		send_sample(20'd519888, 20'd415148);
		send_sample(20'h00000, 20'h00000);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'h00000, 20'hFFFFF);
		send_sample(20'hFFFFF, 20'h00000);
		send_sample(20'h55555, 20'hAAAAA);
		send_sample(20'hAAAAA, 20'h55555);
		send_sample(20'd519888, 20'hFFFFF);
		send_sample(20'd519888, 20'h00001);
		random_samples(270);

		// extremes: max positive words
		load_calib({16'h7FFF, 16'h7FFF, 16'hFFFF}, {4{16'h7FFF}} | 64'hFFFF,
			{4{16'h7FFF}}, 16'h7FFF);
		send_sample(20'h00000, 20'h00000);
		send_sample(20'hFFFFF, 20'hFFFFF);
		random_samples(270);

		// extremes: most negative words
		quiet = 1'b1;
		load_calib({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
			{4{16'h8000}}, 16'h8000);
		send_sample(20'h00000, 20'h00000);
		send_sample(20'hFFFFF, 20'hFFFFF);
		random_samples(270);
		quiet = 1'b0;

		// all ones, then P1 zero with other words typical
		load_calib('1, '1, '1, '1);
		random_samples(270);
		load_calib({16'hFC18, 16'd26435, 16'd27504},
			{16'd2855, 16'd3024, -16'sd10685, 16'd0}, {16'h8FF8, 16'd15500, -16'sd7, 16'd140},
			16'd6000);
		send_sample(20'd519888, 20'd415148);
		random_samples(80);

		// random calibration sets
		for (int k = 0; k < 2; k++) begin
			load_calib(48'({$urandom(), $urandom()}), {$urandom(), $urandom()},
				{$urandom(), $urandom()}, 16'($urandom()));
			random_samples(250);
		end

		drain();
		$display("covered %0d samples over 8 calibration sets, %0d with zero divisor",
			sent, sb.invalid_seen);
		$display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("** baro_temp_pressure_compensation_core: PASSED **");
		else
			$display("** baro_temp_pressure_compensation_core: FAILED **");
		$finish;
	end

endmodule
